// File: rtl/atr_pkg.sv
// Shared types, constants and helpers for the AUX transaction rewriter.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
package atr_pkg;

    localparam int PAYLOAD_BYTES = 16;
    localparam int LANES         = 16;
    localparam int LANE_W        = $clog2(LANES);
    localparam int COUNT_W       = 5;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 8;

    localparam logic [19:0] ADDR_EDID       = 20'h00050;
    localparam logic [19:0] ADDR_LINK_BW    = 20'h00100;
    localparam logic [19:0] ADDR_LANE_COUNT = 20'h00101;
    localparam logic [19:0] ADDR_TRAIN_PAT  = 20'h00102;
    localparam logic [19:0] ADDR_LANE01_ST  = 20'h00202;

    localparam logic [COUNT_W-1:0] SERIAL_MIN_COUNT = 5'd12;
    localparam logic [COUNT_W-1:0] DOCK_MIN_COUNT   = 5'd6;
    localparam logic [LANE_W-1:0]  SERIAL_FIRST     = 4'd8;
    localparam logic [LANE_W-1:0]  SERIAL_LAST      = 4'd11;
    localparam logic [LANE_W-1:0]  DOCK_LAST        = 4'd5;

    localparam logic [7:0] DOCK_FIRST_BYTE = 8'h00;
    localparam logic [7:0] DOCK_FILL_BYTE  = 8'hFF;

    localparam logic [7:0] RESET_RATE_CODE = 8'd30;
    localparam logic [7:0] RESET_LANE_CODE = 8'd4;
    localparam logic [7:0] RESET_FUZZ_SEED = 8'd90;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MASK_SERIAL  = 3'd0,
        CFG_DOCK_EMU     = 3'd1,
        CFG_FUZZ         = 3'd2,
        CFG_SLOW_TRAIN   = 3'd3,
        CFG_HPD_BOUNCE   = 3'd4,
        CFG_RATE_CODE    = 3'd5,
        CFG_LANE_CODE    = 3'd6,
        CFG_FUZZ_SEED    = 3'd7
    } t_cfg_index;

    typedef enum logic [2:0] {
        NOTE_NONE     = 3'd0,
        NOTE_SERIAL   = 3'd1,
        NOTE_RATE     = 3'd2,
        NOTE_LANES    = 3'd3,
        NOTE_DOCK     = 3'd4,
        NOTE_FUZZ     = 3'd5,
        NOTE_TRAINING = 3'd6,
        NOTE_HPD      = 3'd7
    } t_note;

    typedef struct packed {
        logic [19:0]        aux_address;
        logic [COUNT_W-1:0] byte_count;
        logic [63:0]        payload_low;
        logic [63:0]        payload_high;
    } t_atr_in;

    typedef struct packed {
        logic [63:0] rewritten_low;
        logic [63:0] rewritten_high;
        logic        injected;
        logic        hpd_bounce_request;
        logic [2:0]  note_code;
        logic [31:0] serial_override_total;
        logic [31:0] alert_total;
        logic [31:0] training_step_total;
        logic [7:0]  link_rate_seen;
        logic [7:0]  lane_count_seen;
    } t_atr_out;

    typedef struct packed {
        logic       mask_serial;
        logic       dock_emu;
        logic       fuzz;
        logic       slow_train;
        logic       hpd_alert;
        logic [7:0] rate_code;
        logic [7:0] lane_code;
        logic [7:0] seed_base;
    } t_atr_cfg;

    // Rule hits for one transaction, shared by all lanes and the merge stage.
    typedef struct packed {
        logic               serial;
        logic               rate;
        logic               lane;
        logic               dock;
        logic               fuzz;
        logic               training;
        logic               hpd;
        logic [COUNT_W-1:0] count_sat;
    } t_atr_rules;

    typedef logic [LANES-1:0][7:0] t_atr_bytes;

    // Fixed characters for EDID serial bytes 8 to 11.
    function automatic logic [7:0] serial_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h4A;
            2'd1:    c = 8'h41;
            2'd2:    c = 8'h59;
            default: c = 8'h31;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/atr_rule_decode.sv
// Address and byte-count decode that decides which rewrite rules fire.
// Depends on atr_pkg.
`timescale 1ns / 1ps
module atr_rule_decode (
    input  atr_pkg::t_atr_in    i_item,
    input  atr_pkg::t_atr_cfg   i_cfg,
    output atr_pkg::t_atr_rules o_rules
);
    import atr_pkg::*;

    logic [COUNT_W-1:0] count_sat;
    logic               is_edid;

    always_comb begin
        if (i_item.byte_count > COUNT_W'(PAYLOAD_BYTES)) begin
            count_sat = COUNT_W'(PAYLOAD_BYTES);
        end else begin
            count_sat = i_item.byte_count;
        end
        is_edid = (i_item.aux_address == ADDR_EDID);

        o_rules.count_sat = count_sat;
        o_rules.serial    = i_cfg.mask_serial && is_edid && (count_sat >= SERIAL_MIN_COUNT);
        o_rules.rate      = (i_item.aux_address == ADDR_LINK_BW) && (count_sat != '0);
        o_rules.lane      = (i_item.aux_address == ADDR_LANE_COUNT) && (count_sat != '0);
        o_rules.dock      = i_cfg.dock_emu && is_edid && (count_sat >= DOCK_MIN_COUNT);
        o_rules.fuzz      = i_cfg.fuzz && (count_sat != '0);
        o_rules.training  = i_cfg.slow_train && (i_item.aux_address == ADDR_TRAIN_PAT);
        o_rules.hpd       = i_cfg.hpd_alert && (i_item.aux_address == ADDR_LANE01_ST);
    end

endmodule

// File: rtl/atr_byte_lane.sv
// One payload byte lane: applies the byte rewrite rules in order to its byte.
// Depends on atr_pkg.
`timescale 1ns / 1ps
module atr_byte_lane (
    input  logic [atr_pkg::LANE_W-1:0] i_lane_index,
    input  logic [7:0]                 i_byte,
    input  atr_pkg::t_atr_rules        i_rules,
    input  atr_pkg::t_atr_cfg          i_cfg,
    output logic [7:0]                 o_byte
);
    import atr_pkg::*;

    logic       present;
    logic       held;
    logic [7:0] b;

    always_comb begin
        present = ({1'b0, i_lane_index} < i_rules.count_sat);
        held    = ({1'b0, i_lane_index} < COUNT_W'(PAYLOAD_BYTES));
        b       = i_byte;
        if (i_rules.serial && (i_lane_index >= SERIAL_FIRST) &&
            (i_lane_index <= SERIAL_LAST)) begin
            b = serial_char(i_lane_index[1:0]);
        end
        if (i_rules.rate && (i_lane_index == '0)) begin
            b = i_cfg.rate_code;
        end
        if (i_rules.lane && (i_lane_index == '0)) begin
            b = i_cfg.lane_code;
        end
        if (i_rules.dock && (i_lane_index <= DOCK_LAST)) begin
            b = (i_lane_index == '0) ? DOCK_FIRST_BYTE : DOCK_FILL_BYTE;
        end
        if (i_rules.fuzz && present) begin
            b = b ^ 8'(i_cfg.seed_base + {4'b0000, i_lane_index});
        end
        // Bytes beyond the held payload width always read as zero.
        if (!held) begin
            b = 8'h00;
        end
        o_byte = b;
    end

endmodule

// File: rtl/atr_merge.sv
// Merge stage: packs the lane bytes, picks the note code and keeps the
// running counters and recorded codes. Depends on atr_pkg.
`timescale 1ns / 1ps
module atr_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  atr_pkg::t_atr_rules i_rules,
    input  atr_pkg::t_atr_cfg   i_cfg,
    input  atr_pkg::t_atr_bytes i_bytes,
    output atr_pkg::t_atr_out   o_result
);
    import atr_pkg::*;

    logic [31:0] r_serial, n_serial;
    logic [31:0] r_alert, n_alert;
    logic [31:0] r_train, n_train;
    logic [7:0]  r_rate, n_rate;
    logic [7:0]  r_lanes, n_lanes;
    t_note       note;

    always_comb begin
        n_serial = r_serial + 32'(i_rules.serial);
        n_alert  = r_alert + 32'(i_rules.fuzz) + 32'(i_rules.hpd);
        n_train  = r_train + 32'(i_rules.training);
        n_rate   = i_rules.rate ? i_cfg.rate_code : r_rate;
        n_lanes  = i_rules.lane ? i_cfg.lane_code : r_lanes;

        // Later rules take precedence for the note.
        if (i_rules.hpd) begin
            note = NOTE_HPD;
        end else if (i_rules.training) begin
            note = NOTE_TRAINING;
        end else if (i_rules.fuzz) begin
            note = NOTE_FUZZ;
        end else if (i_rules.dock) begin
            note = NOTE_DOCK;
        end else if (i_rules.lane) begin
            note = NOTE_LANES;
        end else if (i_rules.rate) begin
            note = NOTE_RATE;
        end else if (i_rules.serial) begin
            note = NOTE_SERIAL;
        end else begin
            note = NOTE_NONE;
        end

        o_result.rewritten_low         = i_bytes[7:0];
        o_result.rewritten_high        = i_bytes[15:8];
        o_result.injected              = i_rules.serial | i_rules.rate | i_rules.lane |
                                         i_rules.dock | i_rules.fuzz;
        o_result.hpd_bounce_request    = i_rules.hpd;
        o_result.note_code             = note;
        o_result.serial_override_total = n_serial;
        o_result.alert_total           = n_alert;
        o_result.training_step_total   = n_train;
        o_result.link_rate_seen        = n_rate;
        o_result.lane_count_seen       = n_lanes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_serial <= '0;
            r_alert  <= '0;
            r_train  <= '0;
            r_rate   <= '0;
            r_lanes  <= '0;
        end else if (i_accept) begin
            r_serial <= n_serial;
            r_alert  <= n_alert;
            r_train  <= n_train;
            r_rate   <= n_rate;
            r_lanes  <= n_lanes;
        end
    end

endmodule

// File: rtl/aux_transaction_rewriter.sv
// AUX transaction rewriter top level: config registers, rule decode, byte lanes,
// merge stage and a two-entry output buffer. Depends on atr_pkg and submodules.
// Results go to the output register, or to the skid entry when it is held.
// Throughput: one transaction per cycle unless the output buffer fills.
// Reset (synchronous, active low) restores the register defaults, clears all
// counters and recorded codes, and empties the output buffer.
`timescale 1ns / 1ps
module aux_transaction_rewriter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [atr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [atr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input transaction channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  atr_pkg::t_atr_in                i_in_data,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output atr_pkg::t_atr_out               o_out_data
);
    import atr_pkg::*;

    t_atr_cfg   r_cfg;
    t_atr_rules rules;
    t_atr_bytes in_bytes;
    t_atr_bytes out_bytes;
    t_atr_out   result;
    t_atr_out   r_out;
    t_atr_out   r_skid;
    logic       r_out_valid;
    logic       r_skid_valid;
    logic       in_accept;
    logic       out_fire;

    // Configuration registers. Single-bit flags take bit 0 of the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mask_serial <= 1'b0;
            r_cfg.dock_emu    <= 1'b0;
            r_cfg.fuzz        <= 1'b0;
            r_cfg.slow_train  <= 1'b0;
            r_cfg.hpd_alert   <= 1'b0;
            r_cfg.rate_code   <= RESET_RATE_CODE;
            r_cfg.lane_code   <= RESET_LANE_CODE;
            r_cfg.seed_base   <= RESET_FUZZ_SEED;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MASK_SERIAL: r_cfg.mask_serial <= i_cfg_data[0];
                CFG_DOCK_EMU:    r_cfg.dock_emu    <= i_cfg_data[0];
                CFG_FUZZ:        r_cfg.fuzz        <= i_cfg_data[0];
                CFG_SLOW_TRAIN:  r_cfg.slow_train  <= i_cfg_data[0];
                CFG_HPD_BOUNCE:  r_cfg.hpd_alert   <= i_cfg_data[0];
                CFG_RATE_CODE:   r_cfg.rate_code   <= i_cfg_data;
                CFG_LANE_CODE:   r_cfg.lane_code   <= i_cfg_data;
                CFG_FUZZ_SEED:   r_cfg.seed_base   <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // The input side stalls only while the skid entry is occupied, which
    // keeps the stall purely registered.
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_fire   = r_out_valid && !i_out_stall;

    atr_rule_decode u_decode (
        .i_item  (i_in_data),
        .i_cfg   (r_cfg),
        .o_rules (rules)
    );

    // Unpack the payload so that lane g sees payload byte g.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            in_bytes[k]     = i_in_data.payload_low[8*k +: 8];
            in_bytes[k + 8] = i_in_data.payload_high[8*k +: 8];
        end
    end

    // One lane per payload byte; all lanes work on the same transaction
    // in the same cycle.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        atr_byte_lane u_lane (
            .i_lane_index (LANE_W'(g)),
            .i_byte       (in_bytes[g]),
            .i_rules      (rules),
            .i_cfg        (r_cfg),
            .o_byte       (out_bytes[g])
        );
    end

    // The merge stage owns the counters; they advance only on acceptance,
    // so results leave in the same order as transactions arrive.
    atr_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_rules  (rules),
        .i_cfg    (r_cfg),
        .i_bytes  (out_bytes),
        .o_result (result)
    );

    // Output register with a skid entry behind it. A new transaction is
    // taken while a finished result waits; if the output register is held,
    // the new result parks in the skid entry and the input stalls next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : result;
        end
        if (r_out_valid && !out_fire && in_accept) begin
            r_skid <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The skid entry is never filled while the output register is empty.
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    // The skid entry only fills when the output register was held.
    a_skid_fill_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid entry filled while the output was free");

    // A bounce request is always the last rule applied.
    a_hpd_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.hpd_bounce_request) |-> (o_out_data.note_code == NOTE_HPD))
        else $error("bounce request without the matching note code");

endmodule

// File: tb/aux_transaction_rewriter_tb.sv
// Self-checking testbench for aux_transaction_rewriter: directed and random AUX
// transactions under many policy settings, checked against a built-in predictor.
// Depends on atr_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps
module aux_transaction_rewriter_tb;
    import atr_pkg::*;

    // Cycles with no handshake on any port before the run is declared hung.
    localparam int QUIET_LIMIT   = 1000;
    // Extra cycles allowed after the last result before a config write or the end.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 53;
    localparam int REPORT_LIMIT  = 10;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    t_cfg_index i_cfg_index = CFG_MASK_SERIAL;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_atr_in    i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_atr_out   o_out_data;

    aux_transaction_rewriter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the policy registers and of the
    // counters the block keeps. Registers start at their reset defaults.
    // ------------------------------------------------------------------
    logic        pol_mask_serial = 1'b0;
    logic        pol_dock        = 1'b0;
    logic        pol_fuzz        = 1'b0;
    logic        pol_train       = 1'b0;
    logic        pol_hpd         = 1'b0;
    logic [7:0]  pol_rate        = RESET_RATE_CODE;
    logic [7:0]  pol_lane        = RESET_LANE_CODE;
    logic [7:0]  pol_seed        = RESET_FUZZ_SEED;

    logic [31:0] serial_masks    = '0;
    logic [31:0] alerts          = '0;
    logic [31:0] training_steps  = '0;
    logic [7:0]  last_rate       = '0;
    logic [7:0]  last_lane       = '0;

    // How often each rule fired, indexed by its note code; only for the summary.
    int rule_hits [8];

    t_atr_in  pending_txns [$];
    t_atr_out expected_rewrites [$];

    int txns_queued     = 0;
    int txns_accepted   = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int configs_applied = 1;
    int quiet_cycles    = 0;

    // Works out the rewritten transaction and advances the counters exactly
    // as the block does. Rules run in priority order, so the last one that
    // fires owns the note code.
    function automatic t_atr_out rewrite_transaction(input t_atr_in txn);
        logic [15:0][7:0] bytes;
        logic [4:0]       present;
        t_note            note;
        t_atr_out         res;
        res     = '0;
        note    = NOTE_NONE;
        bytes   = {txn.payload_high, txn.payload_low};
        present = (txn.byte_count > 5'd16) ? 5'd16 : txn.byte_count;

        if (pol_mask_serial && txn.aux_address == ADDR_EDID && present >= 5'd12) begin
            // Serial bytes 8 to 11 get a fixed ASCII tag, byte 8 first.
            bytes[11:8]  = {8'h31, 8'h59, 8'h41, 8'h4A};
            res.injected = 1'b1;
            serial_masks = serial_masks + 1;
            note         = NOTE_SERIAL;
        end
        if (txn.aux_address == ADDR_LINK_BW && present != 0) begin
            bytes[0]     = pol_rate;
            last_rate    = pol_rate;
            res.injected = 1'b1;
            note         = NOTE_RATE;
        end
        if (txn.aux_address == ADDR_LANE_COUNT && present != 0) begin
            bytes[0]     = pol_lane;
            last_lane    = pol_lane;
            res.injected = 1'b1;
            note         = NOTE_LANES;
        end
        if (pol_dock && txn.aux_address == ADDR_EDID && present >= 5'd6) begin
            bytes[0]     = DOCK_FIRST_BYTE;
            bytes[5:1]   = {5{DOCK_FILL_BYTE}};
            res.injected = 1'b1;
            note         = NOTE_DOCK;
        end
        if (pol_fuzz && present != 0) begin
            for (int i = 0; i < present; i++) begin
                bytes[i] = bytes[i] ^ (pol_seed + 8'(i));
            end
            res.injected = 1'b1;
            alerts       = alerts + 1;
            note         = NOTE_FUZZ;
        end
        if (pol_train && txn.aux_address == ADDR_TRAIN_PAT) begin
            training_steps = training_steps + 1;
            note           = NOTE_TRAINING;
        end
        if (pol_hpd && txn.aux_address == ADDR_LANE01_ST) begin
            alerts                 = alerts + 1;
            res.hpd_bounce_request = 1'b1;
            note                   = NOTE_HPD;
        end

        if (note != NOTE_NONE) begin
            rule_hits[note]++;
        end
        res.rewritten_low         = bytes[7:0];
        res.rewritten_high        = bytes[15:8];
        res.note_code             = note;
        res.serial_override_total = serial_masks;
        res.alert_total           = alerts;
        res.training_step_total   = training_steps;
        res.link_rate_seen        = last_rate;
        res.lane_count_seen       = last_lane;
        return res;
    endfunction

    // Compares one result with its expectation field by field. Only the
    // first few mismatches are printed; the rest are just counted.
    task automatic check_rewrite(input t_atr_out exp, input t_atr_out act);
        string diffs;
        diffs = "";
        if (act.rewritten_low !== exp.rewritten_low)
            diffs = {diffs, $sformatf(" rewritten_low exp %h got %h",
                                      exp.rewritten_low, act.rewritten_low)};
        if (act.rewritten_high !== exp.rewritten_high)
            diffs = {diffs, $sformatf(" rewritten_high exp %h got %h",
                                      exp.rewritten_high, act.rewritten_high)};
        if (act.injected !== exp.injected)
            diffs = {diffs, $sformatf(" injected exp %b got %b", exp.injected, act.injected)};
        if (act.hpd_bounce_request !== exp.hpd_bounce_request)
            diffs = {diffs, $sformatf(" hpd_bounce_request exp %b got %b",
                                      exp.hpd_bounce_request, act.hpd_bounce_request)};
        if (act.note_code !== exp.note_code)
            diffs = {diffs, $sformatf(" note_code exp %0d got %0d",
                                      exp.note_code, act.note_code)};
        if (act.serial_override_total !== exp.serial_override_total)
            diffs = {diffs, $sformatf(" serial_override_total exp %0d got %0d",
                                      exp.serial_override_total, act.serial_override_total)};
        if (act.alert_total !== exp.alert_total)
            diffs = {diffs, $sformatf(" alert_total exp %0d got %0d",
                                      exp.alert_total, act.alert_total)};
        if (act.training_step_total !== exp.training_step_total)
            diffs = {diffs, $sformatf(" training_step_total exp %0d got %0d",
                                      exp.training_step_total, act.training_step_total)};
        if (act.link_rate_seen !== exp.link_rate_seen)
            diffs = {diffs, $sformatf(" link_rate_seen exp %h got %h",
                                      exp.link_rate_seen, act.link_rate_seen)};
        if (act.lane_count_seen !== exp.lane_count_seen)
            diffs = {diffs, $sformatf(" lane_count_seen exp %h got %h",
                                      exp.lane_count_seen, act.lane_count_seen)};
        if (diffs != "") begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("[%0t] result %0d differs:%s", $realtime, results_checked, diffs);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver. Transactions leave the pending queue in bursts of random
    // length separated by random gaps. The prediction is made at the edge
    // where the transaction is accepted, so it sees the counters in the
    // same order as the block does.
    // ------------------------------------------------------------------
    int   burst_left = 1;
    int   gap_left   = 0;
    logic next_valid;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_rewrites.push_back(rewrite_transaction(i_in_data));
                txns_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_txns.size() != 0) begin
                    i_in_data <= pending_txns.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // Now and then a long back-to-back stretch with no gap.
                        if ($urandom_range(0, 5) == 0) begin
                            burst_left = $urandom_range(20, 40);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 8);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                        end
                    end
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and result-side stall. The stall follows its own pattern:
    // it picks its mode at random from no stall, light random stall,
    // heavy random stall and a fixed periodic stall.
    // ------------------------------------------------------------------
    int stall_mode  = 0;
    int stall_cycle = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rewrites.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("[%0t] result with no transaction waiting: %h",
                             $realtime, o_out_data);
                end
            end else begin
                check_rewrite(expected_rewrites.pop_front(), o_out_data);
            end
            results_checked++;
        end

        stall_cycle++;
        if (stall_cycle % 48 == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 99) < 25);
            2:       i_out_stall <= ($urandom_range(0, 99) < 70);
            default: i_out_stall <= (stall_cycle % 5 < 2);
        endcase
    end

    // Watchdog: any accepted transaction, result or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One register write; the predictor copy follows at once since the
    // block is idle whenever this is called. One-bit registers keep bit 0.
    task automatic write_policy(input t_cfg_index idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_MASK_SERIAL: pol_mask_serial = value[0];
            CFG_DOCK_EMU:    pol_dock        = value[0];
            CFG_FUZZ:        pol_fuzz        = value[0];
            CFG_SLOW_TRAIN:  pol_train       = value[0];
            CFG_HPD_BOUNCE:  pol_hpd         = value[0];
            CFG_RATE_CODE:   pol_rate        = value;
            CFG_LANE_CODE:   pol_lane        = value;
            default:         pol_seed        = value;
        endcase
    endtask

    // Waits until every queued transaction has been accepted and every result
    // has come back, then lets the pipeline settle.
    task automatic wait_for_idle();
        do begin
            @(posedge i_clk);
        end while (txns_accepted != txns_queued || expected_rewrites.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_txn(input logic [19:0] addr, input logic [4:0] count,
                             input logic [63:0] lo, input logic [63:0] hi);
        t_atr_in t;
        t.aux_address  = addr;
        t.byte_count   = count;
        t.payload_low  = lo;
        t.payload_high = hi;
        pending_txns.push_back(t);
        txns_queued++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Codes lean toward the extremes so that 0 and 255 show up often.
    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random transactions mostly hit the addresses the rules decode, with
    // counts around the thresholds; the rest are near misses (one address
    // bit flipped), fully random addresses and oversized counts.
    task automatic queue_random_txn();
        logic [19:0] addr;
        logic [19:0] target;
        logic [4:0]  count;
        logic [63:0] lo;
        logic [63:0] hi;
        case ($urandom_range(0, 4))
            0:       target = ADDR_EDID;
            1:       target = ADDR_LINK_BW;
            2:       target = ADDR_LANE_COUNT;
            3:       target = ADDR_TRAIN_PAT;
            default: target = ADDR_LANE01_ST;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: addr = ADDR_EDID;
            4, 5:       addr = target;
            6:          addr = target ^ (20'h1 << $urandom_range(0, 19));
            default:    addr = 20'($urandom);
        endcase
        case ($urandom_range(0, 11))
            0:       count = 5'd0;
            1:       count = 5'($urandom_range(17, 31));
            2:       count = 5'd16;
            3:       count = ($urandom_range(0, 1) != 0) ? 5'd12 : 5'd11;
            4:       count = ($urandom_range(0, 1) != 0) ? 5'd6 : 5'd5;
            default: count = 5'($urandom_range(1, 16));
        endcase
        lo = rand64();
        hi = rand64();
        if ($urandom_range(0, 15) == 0) begin
            lo = '1;
            hi = '1;
        end
        queue_txn(addr, count, lo, hi);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: only the always-on rate and lane forcing applies.
        queue_txn(ADDR_LINK_BW, 5'd1, rand64(), rand64());
        queue_txn(ADDR_LINK_BW, 5'd0, rand64(), rand64());
        queue_txn(ADDR_LANE_COUNT, 5'd16, rand64(), rand64());
        queue_txn(ADDR_EDID, 5'd16, rand64(), rand64());
        queue_txn(20'hFFFFF, 5'd31, '1, '1);
        queue_txn(20'h00000, 5'd0, '0, '0);
        queue_txn(ADDR_TRAIN_PAT, 5'd4, rand64(), rand64());
        queue_txn(ADDR_LANE01_ST, 5'd2, rand64(), rand64());
        wait_for_idle();

        // Every rule on, codes at their extremes; the seed of 255 makes the
        // fuzz pattern wrap on byte 1.
        write_policy(CFG_MASK_SERIAL, 8'h01);
        write_policy(CFG_DOCK_EMU, 8'hFF);
        write_policy(CFG_FUZZ, 8'h01);
        write_policy(CFG_SLOW_TRAIN, 8'h01);
        write_policy(CFG_HPD_BOUNCE, 8'h01);
        write_policy(CFG_RATE_CODE, 8'hFF);
        write_policy(CFG_LANE_CODE, 8'h00);
        write_policy(CFG_FUZZ_SEED, 8'hFF);
        configs_applied++;
        // Serial and dock thresholds from both sides, an oversized count and
        // an address-only access to the EDID device.
        queue_txn(ADDR_EDID, 5'd12, rand64(), rand64());
        queue_txn(ADDR_EDID, 5'd11, rand64(), rand64());
        queue_txn(ADDR_EDID, 5'd6, rand64(), rand64());
        queue_txn(ADDR_EDID, 5'd5, rand64(), rand64());
        queue_txn(ADDR_EDID, 5'd31, rand64(), rand64());
        queue_txn(ADDR_EDID, 5'd0, rand64(), rand64());
        queue_txn(ADDR_LINK_BW, 5'd1, rand64(), rand64());
        queue_txn(ADDR_LANE_COUNT, 5'd0, rand64(), rand64());
        queue_txn(ADDR_LANE_COUNT, 5'd3, rand64(), rand64());
        queue_txn(ADDR_TRAIN_PAT, 5'd0, rand64(), rand64());
        queue_txn(ADDR_LANE01_ST, 5'd3, rand64(), rand64());
        queue_txn(20'hFFFFF, 5'd16, '1, '1);
        queue_txn(20'h00000, 5'd1, '0, '0);
        wait_for_idle();

        // Random phases. The first one writes the enables with only the
        // upper bits set, which must leave every rule off, and puts the
        // codes at the opposite extremes. Later phases pick everything at random.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            for (int k = 0; k < 8; k++) begin
                if (phase == 0) begin
                    write_policy(t_cfg_index'(k), (k < 5) ? 8'hFE : ((k == 6) ? 8'hFF : 8'h00));
                end else if (k < 5) begin
                    write_policy(t_cfg_index'(k), 8'($urandom_range(0, 255)));
                end else begin
                    write_policy(t_cfg_index'(k), pick_code());
                end
            end
            configs_applied++;
            repeat (PHASE_ITEMS) queue_random_txn();
            wait_for_idle();
        end

        $display("Checked %0d results from %0d transactions under %0d policy settings.",
                 results_checked, txns_accepted, configs_applied);
        $display("Rule hits: serial %0d, rate %0d, lanes %0d, dock %0d, fuzz %0d, %s %0d, hpd %0d",
                 rule_hits[NOTE_SERIAL], rule_hits[NOTE_RATE], rule_hits[NOTE_LANES],
                 rule_hits[NOTE_DOCK], rule_hits[NOTE_FUZZ], "training",
                 rule_hits[NOTE_TRAINING], rule_hits[NOTE_HPD]);
        if (mismatch_count == 0 && expected_rewrites.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
